// ===== sv/swm_pkg.sv =====
// Shared types and constants for the sliding window maximum block.
`timescale 1ns / 1ps

package swm_pkg;

  localparam int VALUE_W  = 32;
  localparam int WINDOW_W = 7;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last_item;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] max_value;
    logic [VALUE_W-1:0] position;
    logic               last_of_run;
  } result_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [VALUE_W-1:0]  position;
    logic                last_item;
    logic [VALUE_W-1:0]  out_position;
    logic [WINDOW_W-1:0] out_count;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_PUSH,
    BK_FETCH,
    BK_EMIT
  } back_state_t;

endpackage

// ===== sv/sliding_window_maximum_top.sv =====
// Top level of the sliding window maximum block.
`timescale 1ns / 1ps

// Streams unsigned 32-bit values and reports, for each position, the maximum over the
// window of window_size values (1 if zero, at most MAX_WINDOW) that starts there,
// clipped at the end of the stream. Once a full window is seen each item yields the
// result for the oldest open position, and the item flagged last_item yields all
// remaining results in position order, the final one marked last_of_run. A small
// queue parts the front from the deque engine, and the engine works on one item at a
// time through a single-port deque memory with registered reads: it compares the item
// with deque entries from the back, removing each one not above it and stopping at a
// larger one, pushes it, and for each result due reads the deque head and emits it.
// A result waits in the engine while the output queue is full. The front accepts up
// to two items ahead of the engine, and two results wait in the output queue.
// window_size must be written only while the block is idle; it does not enforce this.

module sliding_window_maximum_top #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [swm_pkg::WINDOW_W-1:0] cfg_data,
  input  logic                         push,
  output logic                         full,
  input  swm_pkg::item_t               item,
  output logic                         empty,
  input  logic                         pop,
  output swm_pkg::result_t             result
);

  import swm_pkg::*;

  cmd_t    cmd_in;
  cmd_t    cmd_out;
  logic    cmd_wr;
  logic    cmd_full;
  logic    cmd_empty;
  logic    cmd_pop;
  result_t res;
  logic    res_push;
  logic    res_full;

  assign full = cmd_full;

  swm_front #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .push     (push),
    .item     (item),
    .cmd_wr   (cmd_wr),
    .cmd      (cmd_in),
    .cmd_full (cmd_full)
  );

  swm_fifo #(
    .WIDTH($bits(cmd_t))
  ) u_cmd_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (cmd_wr),
    .wr_data(cmd_in),
    .full   (cmd_full),
    .rd_en  (cmd_pop),
    .rd_data(cmd_out),
    .empty  (cmd_empty)
  );

  swm_back #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_empty(cmd_empty),
    .cmd      (cmd_out),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res)
  );

  swm_fifo #(
    .WIDTH($bits(result_t))
  ) u_res_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (res_push),
    .wr_data(res),
    .full   (res_full),
    .rd_en  (pop),
    .rd_data(result),
    .empty  (empty)
  );

endmodule

// ===== sv/swm_fifo.sv =====
// Two-entry queue used between the front, the deque engine and the result port.
`timescale 1ns / 1ps

module swm_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic             do_wr;
  logic             do_rd;

  assign full    = (fill == 2'd2);
  assign empty   = (fill == 2'd0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 2'd1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== sv/swm_front.sv =====
// Front end: window register, stream positions and the result plan for each item.
`timescale 1ns / 1ps

module swm_front #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [swm_pkg::WINDOW_W-1:0]    cfg_data,
  input  logic                            push,
  input  swm_pkg::item_t                  item,
  output logic                            cmd_wr,
  output swm_pkg::cmd_t                   cmd,
  input  logic                            cmd_full
);

  import swm_pkg::*;

  logic [WINDOW_W-1:0] window_size;
  logic [WINDOW_W-1:0] win_eff;
  logic [VALUE_W-1:0]  items_seen;
  logic [VALUE_W-1:0]  next_pos;
  logic [VALUE_W-1:0]  seen_next;
  logic [VALUE_W-1:0]  pending;
  logic                emit;

  assign cfg_ready = 1'b1;
  assign cmd_wr    = push && !cmd_full;

  always_comb begin
    if (window_size == '0) begin
      win_eff = WINDOW_W'(1);
    end else if (window_size > WINDOW_W'(MAX_WINDOW)) begin
      win_eff = WINDOW_W'(MAX_WINDOW);
    end else begin
      win_eff = window_size;
    end
    seen_next = items_seen + VALUE_W'(1);
    pending   = seen_next - next_pos;
    emit      = !item.last_item && (pending >= VALUE_W'(win_eff));

    cmd.value        = item.value;
    cmd.position     = items_seen;
    cmd.last_item    = item.last_item;
    cmd.out_position = next_pos;
    if (item.last_item) begin
      if (pending > VALUE_W'(MAX_WINDOW)) begin
        cmd.out_count = WINDOW_W'(MAX_WINDOW);
      end else begin
        cmd.out_count = pending[WINDOW_W-1:0];
      end
    end else begin
      cmd.out_count = emit ? WINDOW_W'(1) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_W'(1);
      items_seen  <= '0;
      next_pos    <= '0;
    end else begin
      if (cfg_valid) begin
        window_size <= cfg_data;
      end
      if (cmd_wr) begin
        if (item.last_item) begin
          items_seen <= '0;
          next_pos   <= '0;
        end else begin
          items_seen <= seen_next;
          if (emit) begin
            next_pos <= next_pos + VALUE_W'(1);
          end
        end
      end
    end
  end

endmodule

// ===== sv/swm_back.sv =====
// Deque engine: monotonic deque in a memory, back pops, push, front pops and result emission.
`timescale 1ns / 1ps

module swm_back #(
  parameter int MAX_WINDOW = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_empty,
  input  swm_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  input  logic             res_full,
  output logic             res_push,
  output swm_pkg::result_t res
);

  import swm_pkg::*;

  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int HEAD_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUM_W  = CNT_W + 1;

  function automatic logic [HEAD_W-1:0] slot(input logic [HEAD_W-1:0] base,
                                             input logic [CNT_W-1:0]  k);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(k);
    if (sum >= SUM_W'(MAX_WINDOW)) begin
      sum = sum - SUM_W'(MAX_WINDOW);
    end
    return sum[HEAD_W-1:0];
  endfunction

  logic [VALUE_W-1:0]  mem_values    [MAX_WINDOW];
  logic [VALUE_W-1:0]  mem_positions [MAX_WINDOW];

  back_state_t         state;
  back_state_t         state_next;
  logic [HEAD_W-1:0]   head;
  logic [HEAD_W-1:0]   head_next;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  cmd_t                cur;
  logic [VALUE_W-1:0]  out_pos;
  logic [VALUE_W-1:0]  out_pos_next;
  logic [WINDOW_W-1:0] remaining;
  logic [WINDOW_W-1:0] remaining_next;
  logic [VALUE_W-1:0]  rd_value;
  logic [VALUE_W-1:0]  rd_position;

  logic                rd_en;
  logic [HEAD_W-1:0]   rd_addr;
  logic                wr_en;
  logic [HEAD_W-1:0]   wr_addr;
  logic                front_match;
  logic [CNT_W-1:0]    cnt_after;
  logic [HEAD_W-1:0]   head_after;
  logic                done;

  always_comb begin
    state_next     = state;
    head_next      = head;
    count_next     = count;
    out_pos_next   = out_pos;
    remaining_next = remaining;
    cmd_pop        = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = head;
    wr_en          = 1'b0;
    wr_addr        = slot(head, count);
    res_push       = 1'b0;
    front_match    = (rd_position == out_pos);
    cnt_after      = count - CNT_W'(front_match);
    head_after     = front_match ? slot(head, CNT_W'(1)) : head;
    done           = (remaining == WINDOW_W'(1)) || (cnt_after == '0);
    res.max_value   = rd_value;
    res.position    = out_pos;
    res.last_of_run = cur.last_item && done;

    unique case (state)
      BK_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          if (count == '0) begin
            state_next = BK_PUSH;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = slot(head, count - CNT_W'(1));
            state_next = BK_SCAN;
          end
        end
      end
      BK_SCAN: begin
        if (rd_value <= cur.value) begin
          count_next = count - CNT_W'(1);
          if (count == CNT_W'(1)) begin
            state_next = BK_PUSH;
          end else begin
            rd_en   = 1'b1;
            rd_addr = slot(head, count - CNT_W'(2));
          end
        end else begin
          state_next = BK_PUSH;
        end
      end
      BK_PUSH: begin
        wr_en          = 1'b1;
        out_pos_next   = cur.out_position;
        remaining_next = cur.out_count;
        if (count == CNT_W'(MAX_WINDOW)) begin
          head_next = slot(head, CNT_W'(1));
        end else begin
          count_next = count + CNT_W'(1);
        end
        if (cur.out_count != '0) begin
          state_next = BK_FETCH;
        end else begin
          state_next = BK_IDLE;
          if (cur.last_item) begin
            head_next  = '0;
            count_next = '0;
          end
        end
      end
      BK_FETCH: begin
        rd_en      = 1'b1;
        rd_addr    = head;
        state_next = BK_EMIT;
      end
      BK_EMIT: begin
        if (!res_full) begin
          res_push       = 1'b1;
          out_pos_next   = out_pos + VALUE_W'(1);
          remaining_next = remaining - WINDOW_W'(1);
          head_next      = head_after;
          count_next     = cnt_after;
          if (done) begin
            state_next = BK_IDLE;
            if (cur.last_item) begin
              head_next  = '0;
              count_next = '0;
            end
          end else begin
            rd_en   = 1'b1;
            rd_addr = head_after;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
    end
    out_pos   <= out_pos_next;
    remaining <= remaining_next;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_values[wr_addr]    <= cur.value;
      mem_positions[wr_addr] <= cur.position;
    end
    if (rd_en) begin
      rd_value    <= mem_values[rd_addr];
      rd_position <= mem_positions[rd_addr];
    end
  end

endmodule

// ===== sv/swm_checker.sv =====
// Port-level checks for the sliding window maximum block and their binding.
`timescale 1ns / 1ps

module swm_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         full,
  input logic                         empty,
  input logic                         pop,
  input swm_pkg::result_t             result
);

  import swm_pkg::*;

  logic [VALUE_W-1:0] exp_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_pos <= '0;
    end else if (pop && !empty) begin
      exp_pos <= result.last_of_run ? '0 : result.position + VALUE_W'(1);
    end
  end

  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("Result queue not empty after reset.");

  a_position_order: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty) |-> (result.position == exp_pos))
    else $error("Result item out of position order.");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("Waiting result item changed or vanished.");

  a_not_full_after_reset: assert property (@(posedge clk) rst |=> !full)
    else $error("Input reports full after reset.");

endmodule

bind sliding_window_maximum_top swm_checker u_swm_checker (.*);
